// ----- sv/unique_value_stack_assert.svh -----
// Assertion macros shared by the unique value stack RTL.
`ifndef UNIQUE_VALUE_STACK_ASSERT_SVH
`define UNIQUE_VALUE_STACK_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define UVS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("unique_value_stack: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define UVS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("unique_value_stack: next-cycle check failed");

`endif

// ----- sv/uvs_pkg.sv -----
// Shared types and constants for the unique value stack.
package uvs_pkg;

   localparam int DEPTH      = 128;
   localparam int VALUE_W    = 32;
   localparam int COUNT_W    = $clog2(DEPTH + 1);
   localparam int GROUP_SIZE = 16;
   localparam int NUM_GROUPS = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int PAD_W      = NUM_GROUPS * GROUP_SIZE;

   typedef logic signed [VALUE_W-1:0] uvs_value_type;
   typedef logic [COUNT_W-1:0]        uvs_count_type;

   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   typedef enum logic [2:0] {
      ST_PUSHED    = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_FULL      = 3'd2,
      ST_POPPED    = 3'd3,
      ST_EMPTY     = 3'd4
   } uvs_status_type;

   // Shift control broadcast to every cell of the chain.
   typedef struct packed {
      logic shift_up;
      logic shift_down;
   } uvs_shift_type;

endpackage

// ----- sv/uvs_cell.sv -----
// One stack cell: holds an entry, shifts with its neighbors, flags a match.
module uvs_cell
   import uvs_pkg::*;
(
   input  logic          clock,
   input  uvs_shift_type shift,
   input  uvs_value_type from_below,
   input  uvs_value_type from_above,
   input  uvs_value_type push_value,
   input  logic          active,
   output uvs_value_type value_out,
   output logic          match_out
);

   uvs_value_type value_ff;
   uvs_value_type value_in;
   logic          match_ff;
   logic          match_in;

   always_comb begin
      value_in = value_ff;
      if (shift.shift_up) begin
         value_in = from_below;
      end else if (shift.shift_down) begin
         value_in = from_above;
      end
   end

   assign match_in = active && (value_ff == push_value);

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      match_ff <= match_in;
   end

   assign value_out = value_ff;
   assign match_out = match_ff;

endmodule

// ----- sv/uvs_match_tree.sv -----
// Registered OR tree over the per-cell match flags.
module uvs_match_tree
   import uvs_pkg::*;
(
   input  logic             clock,
   input  logic [DEPTH-1:0] match,
   output logic             any
);

   logic [PAD_W-1:0]      padded;
   logic [NUM_GROUPS-1:0] group_ff;
   logic [NUM_GROUPS-1:0] group_in;

   always_comb begin
      padded = '0;
      padded[DEPTH-1:0] = match;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         group_in[g] = |padded[g*GROUP_SIZE +: GROUP_SIZE];
      end
   end

   always_ff @(posedge clock) begin
      group_ff <= group_in;
   end

   assign any = |group_ff;

endmodule

// ----- sv/unique_value_stack.sv -----
// Top level of the unique value stack: request control and the cell chain.
//
// LIFO stack of signed 32-bit values that refuses duplicates.
// Request channel (req_): tuser selects push (0) or pop (1), tdata carries the
// value to push. Response channel (rsp_): tuser is the status code (pushed,
// duplicate, full, popped, empty), tdata the echoed or popped value, zero
// when full or empty. Every request gives exactly one response.
// The stack is a row of cells with the top entry in cell 0; a push shifts the
// row up, a pop shifts it down. Each cell compares its entry with the pushed
// value; the flags are gathered by a two-level registered OR tree.
// Each request passes through accept, cell compare, group OR and commit in
// turn. One request is in progress at a time, so a new request is taken only
// after the commit of the previous one.
// While a response waits on rsp_tready the next request is still accepted;
// its commit holds until the output register is free.
// Reset empties the stack and drops any pending response; entry contents are
// not cleared.
module unique_value_stack
   import uvs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] push_value
   input  logic        req_tuser,   // [0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] out_value
   output logic [2:0]  rsp_tuser    // [2:0] status
);

`include "unique_value_stack_assert.svh"

   typedef enum logic [1:0] {
      S_IDLE,
      S_CMP,
      S_RED,
      S_COMMIT
   } state_type;

   localparam uvs_count_type COUNT_ONE  = uvs_count_type'(1);
   localparam uvs_count_type COUNT_FULL = uvs_count_type'(DEPTH);

   state_type      state_ff;
   logic           req_type_ff;
   uvs_value_type  req_value_ff;
   uvs_count_type  count_ff;
   logic           rsp_valid_ff;
   uvs_status_type rsp_status_ff;
   uvs_value_type  rsp_value_ff;

   uvs_status_type status_in;
   uvs_value_type  out_value_in;
   uvs_shift_type  shift;
   logic           commit_fire;
   logic           any_match;

   uvs_value_type    cell_value [DEPTH];
   logic [DEPTH-1:0] cell_match;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      uvs_value_type below;
      uvs_value_type above;
      if (i == 0) begin : g_top
         assign below = req_value_ff;
      end else begin : g_inner
         assign below = cell_value[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign above = cell_value[i];
      end else begin : g_mid
         assign above = cell_value[i+1];
      end
      uvs_cell u_cell (
         .clock      (clock),
         .shift      (shift),
         .from_below (below),
         .from_above (above),
         .push_value (req_value_ff),
         .active     (uvs_count_type'(i) < count_ff),
         .value_out  (cell_value[i]),
         .match_out  (cell_match[i])
      );
   end

   uvs_match_tree u_match_tree (
      .clock (clock),
      .match (cell_match),
      .any   (any_match)
   );

   assign commit_fire = (state_ff == S_COMMIT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      status_in    = ST_EMPTY;
      out_value_in = '0;
      shift        = '0;
      if (req_type_ff == REQ_POP) begin
         if (count_ff != '0) begin
            status_in        = ST_POPPED;
            out_value_in     = cell_value[0];
            shift.shift_down = commit_fire;
         end
      end else if (count_ff == COUNT_FULL) begin
         status_in = ST_FULL;
      end else if (any_match) begin
         status_in    = ST_DUPLICATE;
         out_value_in = req_value_ff;
      end else begin
         status_in      = ST_PUSHED;
         out_value_in   = req_value_ff;
         shift.shift_up = commit_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && !commit_fire) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  req_type_ff  <= req_tuser;
                  req_value_ff <= req_tdata;
                  state_ff     <= S_CMP;
               end
            end
            S_CMP: begin
               state_ff <= S_RED;
            end
            S_RED: begin
               state_ff <= S_COMMIT;
            end
            S_COMMIT: begin
               if (commit_fire) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_in;
                  rsp_value_ff  <= out_value_in;
                  if (shift.shift_up) begin
                     count_ff <= count_ff + COUNT_ONE;
                  end else if (shift.shift_down) begin
                     count_ff <= count_ff - COUNT_ONE;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;

   `UVS_ASSERT_NOW(a_count_range, clock, reset, 1'b1, count_ff <= COUNT_FULL)
   `UVS_ASSERT_NEXT(a_push_grows, clock, reset, commit_fire && status_in == ST_PUSHED,
      count_ff == $past(count_ff) + COUNT_ONE)
   `UVS_ASSERT_NOW(a_empty_at_zero, clock, reset, commit_fire && status_in == ST_EMPTY,
      count_ff == '0)
   `UVS_ASSERT_NOW(a_no_double_shift, clock, reset, 1'b1,
      !(shift.shift_up && shift.shift_down))

endmodule
